// ----- rtl/aks_pkg.sv -----
// Package for the AES-256 counter-mode keystream block.
// Holds the controller/datapath types, register indexes and the AES round functions.
// No dependencies.
package aks_pkg;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROUND,
      ST_EMIT
   } aks_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic init;
      logic round;
      logic emit;
   } aks_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic ks_valid;
      logic last_round;
      logic out_free;
   } aks_status_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_KEY_0        = 3'd0;
   localparam logic [2:0] CSR_KEY_1        = 3'd1;
   localparam logic [2:0] CSR_KEY_2        = 3'd2;
   localparam logic [2:0] CSR_KEY_3        = 3'd3;
   localparam logic [2:0] CSR_CTR_HIGH     = 3'd4;
   localparam logic [2:0] CSR_CTR_LOW      = 3'd5;
   localparam logic [2:0] CSR_START_OFFSET = 3'd6;

   localparam logic [3:0] FIRST_ROUND = 4'd1;
   localparam logic [3:0] LAST_ROUND  = 4'd14;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // Round constant for key words at multiples of eight
   function automatic logic [7:0] rcon(input logic [2:0] j);
      logic [7:0] r;
      case (j)
         3'd1:    r = 8'h01;
         3'd2:    r = 8'h02;
         3'd3:    r = 8'h04;
         3'd4:    r = 8'h08;
         3'd5:    r = 8'h10;
         3'd6:    r = 8'h20;
         3'd7:    r = 8'h40;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // SubBytes, ShiftRows and (unless skipped) MixColumns; byte 0 in bits 127:120
   function automatic logic [127:0] aes_round(input logic [127:0] s_in, input logic skip_mix);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, all;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) s[i] = SBOX[s_in[127-8*i -: 8]];
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i) & 3)];
      for (int c = 0; c < 4; c++) begin
         a0  = t[4*c];
         a1  = t[4*c+1];
         a2  = t[4*c+2];
         a3  = t[4*c+3];
         all = a0 ^ a1 ^ a2 ^ a3;
         if (!skip_mix) begin
            s[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            s[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            s[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            s[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end else begin
            s[4*c]   = a0;
            s[4*c+1] = a1;
            s[4*c+2] = a2;
            s[4*c+3] = a3;
         end
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
      return res;
   endfunction

endpackage

// ----- rtl/aks_ctrl.sv -----
// Controller state machine for the AES-256 counter-mode keystream block.
// Depends on aks_pkg.
module aks_ctrl import aks_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_reload_counter,
   output logic           req_stall,
   input  aks_status_type status,
   output aks_cmd_type    cmd,
   output aks_state_type  state
);

   aks_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_reload_counter || !status.ks_valid) ? ST_INIT : ST_EMIT;
            end
         end
         ST_INIT:  state_in = ST_ROUND;
         ST_ROUND: begin
            if (status.last_round) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_INIT:  cmd.init  = 1'b1;
         ST_ROUND: cmd.round = 1'b1;
         ST_EMIT:  cmd.emit  = status.out_free;
         default:  cmd       = '0;
      endcase
   end

   assign state = state_ff;

endmodule

// ----- rtl/aks_datapath.sv -----
// Datapath for the AES-256 counter-mode keystream block: config registers,
// counter, on-the-fly key schedule, one AES round per cycle, output register.
// Depends on aks_pkg.
module aks_datapath import aks_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_valid,
   input  logic [2:0]     csr_index,
   input  logic [63:0]    csr_data,
   input  logic [7:0]     req_data_byte,
   input  logic           req_reload_counter,
   input  logic           req_end_of_message,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_end_of_message_out,
   input  aks_cmd_type    cmd,
   output aks_status_type status
);

   logic [255:0] key_ff;
   logic [127:0] cinit_ff;
   logic [3:0]   start_off_ff;
   logic [127:0] ctr_ff;
   logic [3:0]   off_ff;
   logic [127:0] ks_ff;
   logic         ks_valid_ff;
   logic [127:0] st_ff, st_in;
   logic [255:0] win_ff;
   logic [3:0]   rnd_ff;
   logic [7:0]   data_ff;
   logic         eom_ff;
   logic [7:0]   rsp_byte_ff;
   logic         rsp_eom_ff;
   logic         rsp_valid_ff;
   logic [31:0]  t_word, n0, n1, n2, n3;
   logic [127:0] rk_in;
   logic [127:0] ks_shift;

   // Next four key words from the eight-word window
   always_comb begin
      if (!rnd_ff[0]) begin
         t_word = sub_word({win_ff[23:0], win_ff[31:24]}) ^ {rcon(rnd_ff[3:1]), 24'h0};
      end else begin
         t_word = sub_word(win_ff[31:0]);
      end
      n0 = win_ff[255:224] ^ t_word;
      n1 = win_ff[223:192] ^ n0;
      n2 = win_ff[191:160] ^ n1;
      n3 = win_ff[159:128] ^ n2;
      rk_in = (rnd_ff == FIRST_ROUND) ? win_ff[127:0] : {n0, n1, n2, n3};
      st_in = aes_round(st_ff, rnd_ff == LAST_ROUND) ^ rk_in;
   end

   // Keystream byte at the current offset
   assign ks_shift = ks_ff >> {~off_ff, 3'b000};

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         cinit_ff     <= '0;
         start_off_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY_0:        key_ff[255:192] <= csr_data;
            CSR_KEY_1:        key_ff[191:128] <= csr_data;
            CSR_KEY_2:        key_ff[127:64]  <= csr_data;
            CSR_KEY_3:        key_ff[63:0]    <= csr_data;
            CSR_CTR_HIGH:     cinit_ff[127:64] <= csr_data;
            CSR_CTR_LOW:      cinit_ff[63:0]   <= csr_data;
            CSR_START_OFFSET: start_off_ff    <= csr_data[3:0];
            default:          ;
         endcase
      end
   end

   // Counter, offset and keystream state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff      <= '0;
         off_ff      <= '0;
         ks_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && (csr_index inside {CSR_KEY_0, CSR_KEY_1, CSR_KEY_2, CSR_KEY_3}))
         begin
            ks_valid_ff <= 1'b0;
         end
         if (cmd.accept && req_reload_counter) begin
            ctr_ff      <= cinit_ff;
            off_ff      <= start_off_ff;
            ks_valid_ff <= 1'b0;
         end
         if (cmd.round && rnd_ff == LAST_ROUND) ks_valid_ff <= 1'b1;
         if (cmd.emit) begin
            off_ff <= off_ff + 4'd1;
            if (off_ff == 4'hf) begin
               ctr_ff      <= ctr_ff + 128'd1;
               ks_valid_ff <= 1'b0;
            end
         end
      end
   end

   // Item latch and AES rounds
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff <= req_data_byte;
         eom_ff  <= req_end_of_message;
      end
      if (cmd.init) begin
         st_ff  <= ctr_ff ^ key_ff[255:128];
         win_ff <= key_ff;
         rnd_ff <= FIRST_ROUND;
      end
      if (cmd.round) begin
         st_ff  <= st_in;
         rnd_ff <= rnd_ff + 4'd1;
         if (rnd_ff != FIRST_ROUND) win_ff <= {win_ff[127:0], n0, n1, n2, n3};
         if (rnd_ff == LAST_ROUND) ks_ff <= st_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff <= data_ff ^ ks_shift[7:0];
         rsp_eom_ff  <= eom_ff;
      end
   end

   assign status.ks_valid        = ks_valid_ff;
   assign status.last_round      = (rnd_ff == LAST_ROUND);
   assign status.out_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_out_byte           = rsp_byte_ff;
   assign rsp_end_of_message_out = rsp_eom_ff;

endmodule

// ----- rtl/aes256_ctr_keystream_xor.sv -----
// Channel  | dir | handshake               | payload
// req_     | in  | req_valid / req_stall   | data_byte, reload_counter, end_of_message
// rsp_     | out | rsp_valid / rsp_stall   | out_byte, end_of_message_out
// csr_     | in  | csr_valid / csr_ready   | index (3 bits), data (64 bits)
//
// A byte whose keystream block is ready passes through accept and emit; a byte that
// needs a new block (block boundary, reload or key change) also goes through one
// load and fourteen rounds through the single AES round unit with on-the-fly key
// schedule. Reset is synchronous; it clears the configuration, counter, offset and
// output valid registers and marks the keystream block invalid. One result
// is held in the output register while the next item is taken.
// Top level; depends on aks_pkg, aks_ctrl and aks_datapath.
module aes256_ctr_keystream_xor import aks_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_reload_counter,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_message_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   aks_cmd_type    cmd;
   aks_status_type status;
   aks_state_type  state;

   assign csr_ready = 1'b1;

   aks_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_reload_counter (req_reload_counter),
      .req_stall          (req_stall),
      .status             (status),
      .cmd                (cmd),
      .state              (state)
   );

   aks_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid && csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_data_byte          (req_data_byte),
      .req_reload_counter     (req_reload_counter),
      .req_end_of_message     (req_end_of_message),
      .rsp_stall              (rsp_stall),
      .rsp_valid              (rsp_valid),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_end_of_message_out (rsp_end_of_message_out),
      .cmd                    (cmd),
      .status                 (status)
   );

   // After an item is taken the block is busy with it
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while previous item still in progress");

   // A reload always forces a fresh block computation
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_reload_counter) |=> (state == ST_INIT))
      else $error("reload did not start keystream computation");

   // The keystream is valid whenever a result is produced
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.ks_valid)
      else $error("result produced without a valid keystream block");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for aes256_ctr_keystream_xor: AES-256 CTR byte stream checked
// against an in-bench keystream predictor under random handshake idling and stalls.
// Depends on aks_pkg (register indexes, S-box) and the RTL top level.
module testbench import aks_pkg::*; ();

   typedef struct {
      logic [7:0] out_byte;
      logic       eom;
   } xor_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_reload_counter;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_message_out;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   // predictor state: registers and keystream position
   logic [63:0]    key_regs [4];
   logic [127:0]   counter_init;
   logic [3:0]     offset_init;
   logic [127:0]   block_ctr;
   logic [3:0]     byte_pos;
   logic [127:0]   ks_block;
   logic           ks_ok;
   logic [31:0]    round_keys [60];
   xor_result_type expected_bytes [$];

   int mismatches;
   int failures;
   int burst_left;
   int hold_cycles;
   int stall_mode;
   int stall_tick;

   localparam logic [2:0] CSR_UNUSED = 3'd7;

   aes256_ctr_keystream_xor dut (.*);

   // clock, period 4 ns
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ---------------- keystream predictor ----------------
   function automatic logic [7:0] gf_double(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sbox_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic void expand_round_keys();
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      for (int i = 0; i < 8; i++) round_keys[i] = key_regs[i/2][63-32*(i%2) -: 32];
      for (int i = 8; i < 60; i++) begin
         t = round_keys[i-1];
         if (i % 8 == 0) begin
            t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gf_double(rc);
         end else if (i % 8 == 4) begin
            t = sbox_word(t);
         end
         round_keys[i] = round_keys[i-8] ^ t;
      end
   endfunction

   function automatic logic [127:0] round_key(input int r);
      return {round_keys[4*r], round_keys[4*r+1], round_keys[4*r+2], round_keys[4*r+3]};
   endfunction

   function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, sum;
      logic [127:0] st;
      st = blk ^ round_key(0);
      for (int r = 1; r <= 14; r++) begin
         for (int i = 0; i < 16; i++) s[i] = SBOX[st[127-8*i -: 8]];
         // shift rows
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i) % 4)];
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c];
            a1 = t[4*c+1];
            a2 = t[4*c+2];
            a3 = t[4*c+3];
            sum = a0 ^ a1 ^ a2 ^ a3;
            if (r != 14) begin
               t[4*c]   = a0 ^ sum ^ gf_double(a0 ^ a1);
               t[4*c+1] = a1 ^ sum ^ gf_double(a1 ^ a2);
               t[4*c+2] = a2 ^ sum ^ gf_double(a2 ^ a3);
               t[4*c+3] = a3 ^ sum ^ gf_double(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[127-8*i -: 8] = t[i];
         st = st ^ round_key(r);
      end
      return st;
   endfunction

   function automatic xor_result_type predict_byte(input logic [7:0] d, input logic reload,
                                                   input logic eom);
      xor_result_type res;
      if (reload) begin
         block_ctr = counter_init;
         byte_pos  = offset_init;
         ks_ok     = 1'b0;
      end
      if (!ks_ok) begin
         ks_block = encrypt_block(block_ctr);
         ks_ok    = 1'b1;
      end
      res.out_byte = d ^ ks_block[127-8*byte_pos -: 8];
      res.eom      = eom;
      byte_pos = byte_pos + 4'd1;
      if (byte_pos == 4'd0) begin
         block_ctr = block_ctr + 128'd1;
         ks_ok     = 1'b0;
      end
      return res;
   endfunction

   function automatic void model_csr_write(input logic [2:0] idx, input logic [63:0] value);
      case (idx)
         CSR_KEY_0, CSR_KEY_1, CSR_KEY_2, CSR_KEY_3: begin
            key_regs[idx] = value;
            expand_round_keys();
            ks_ok = 1'b0;
         end
         CSR_CTR_HIGH:     counter_init[127:64] = value;
         CSR_CTR_LOW:      counter_init[63:0]   = value;
         CSR_START_OFFSET: offset_init          = value[3:0];
         default: ;
      endcase
   endfunction

   // ---------------- drivers ----------------
   task automatic send_byte(input logic [7:0] d, input logic reload, input logic eom);
      int gap;
      @(negedge clock);
      req_valid          <= 1'b1;
      req_data_byte      <= d;
      req_reload_counter <= reload;
      req_end_of_message <= eom;
      do @(posedge clock); while (req_stall);
      expected_bytes.push_back(predict_byte(d, reload, eom));
      // bursts with random gaps
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // wait until every expected item has come out and the block has settled
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      model_csr_write(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return 64'h0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // ---------------- tests ----------------
   task automatic test_reset_state();
      // zero key, zero counter, offset 0, no reload needed
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hff, 1'b0, 1'b1);
      send_byte(8'h5a, 1'b0, 1'b0);
      drain();
   endtask

   task automatic test_counter_wrap();
      write_csr(CSR_KEY_0, 64'h0001020304050607);
      write_csr(CSR_KEY_1, 64'h08090a0b0c0d0e0f);
      write_csr(CSR_KEY_2, 64'h1011121314151617);
      write_csr(CSR_KEY_3, 64'h18191a1b1c1d1e1f);
      write_csr(CSR_CTR_HIGH, '1);
      write_csr(CSR_CTR_LOW, '1);
      write_csr(CSR_START_OFFSET, 64'hf);
      write_csr(CSR_UNUSED, 64'h0123456789abcdef);
      // last byte of the all-ones block, then the first of block zero
      send_byte(8'hff, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h81, 1'b0, 1'b0);
      drain();
   endtask

   task automatic test_key_change();
      // new key mid-block: same counter and offset, recomputed block
      write_csr(CSR_KEY_2, 64'hdeadbeefcafef00d);
      send_byte(8'h3c, 1'b0, 1'b0);
      send_byte(8'hc3, 1'b0, 1'b1);
      drain();
   endtask

   task automatic test_reload();
      // counter writes stay silent until a reload
      write_csr(CSR_CTR_HIGH, 64'h0);
      write_csr(CSR_CTR_LOW, 64'h7);
      write_csr(CSR_START_OFFSET, 64'h0);
      send_byte(8'h11, 1'b0, 1'b0);
      send_byte(8'h22, 1'b1, 1'b0);
      send_byte(8'h33, 1'b1, 1'b1);
      send_byte(8'h44, 1'b0, 1'b0);
      drain();
   endtask

   task automatic test_receiver_hold();
      hold_cycles = 300;
      for (int i = 0; i < 40; i++) send_byte(8'($urandom), i == 0, i == 39);
      drain();
   endtask

   task automatic test_random_streams(input int phases, input int items_per_phase);
      int sent, len;
      for (int p = 0; p < phases; p++) begin
         for (int r = 0; r < 7; r++) write_csr(3'(r), pick_word());
         if ($urandom_range(0, 2) == 0) write_csr(CSR_START_OFFSET, $urandom_range(0, 1) ? 15 : 0);
         if ($urandom_range(0, 3) == 0) write_csr(CSR_CTR_LOW, 64'hffff_ffff_ffff_fffe);
         sent = 0;
         while (sent < items_per_phase) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 6) == 0)
                  send_byte(8'($urandom), 1'($urandom), 1'($urandom));
               else
                  send_byte(8'($urandom), i == 0 && $urandom_range(0, 4) != 0, i == len - 1);
            end
            sent += len;
         end
         drain();
      end
   endtask

   // ---------------- receiver stall pattern ----------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_tick <= 0;
         stall_mode <= 0;
      end else begin
         stall_tick <= stall_tick + 1;
         if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 2);
         if (hold_cycles > 0) begin
            rsp_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
         end else begin
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 2) == 0);
               default: rsp_stall <= (stall_tick % 5 < 2);
            endcase
         end
      end
   end

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      xor_result_type exp_item;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            failures++;
            $display("unexpected item: out_byte %h eom %b", rsp_out_byte,
                     rsp_end_of_message_out);
         end else begin
            exp_item = expected_bytes.pop_front();
            if (rsp_out_byte !== exp_item.out_byte ||
                rsp_end_of_message_out !== exp_item.eom) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: out_byte exp %h got %h, eom exp %b got %b",
                           exp_item.out_byte, rsp_out_byte, exp_item.eom,
                           rsp_end_of_message_out);
            end
         end
      end
   end

   // watchdog
   initial begin
      #5ms;
      $display("** aes256_ctr_keystream_xor: FAILED **");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data_byte      = 8'h00;
      req_reload_counter = 1'b0;
      req_end_of_message = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = CSR_KEY_0;
      csr_data           = 64'h0;
      mismatches         = 0;
      failures           = 0;
      burst_left         = 0;
      hold_cycles        = 0;
      for (int i = 0; i < 4; i++) key_regs[i] = 64'h0;
      counter_init = '0;
      offset_init  = '0;
      block_ctr    = '0;
      byte_pos     = '0;
      ks_block     = '0;
      ks_ok        = 1'b0;
      expand_round_keys();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_counter_wrap();
      test_key_change();
      test_reload();
      test_receiver_hold();
      test_random_streams(8, 190);

      drain();
      if (mismatches == 0 && failures == 0 && expected_bytes.size() == 0)
         $display("** aes256_ctr_keystream_xor: PASSED **");
      else
         $display("** aes256_ctr_keystream_xor: FAILED **");
      $finish;
   end

endmodule
